// ===== sv/usmq_pkg.sv =====
package usmq_pkg;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_ERASE    = 3'd1;
  localparam logic [2:0] OP_CONTAINS = 3'd2;
  localparam logic [2:0] OP_GET      = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SHIFT_INIT,
    ST_SHIFT,
    ST_GET_RD,
    ST_FINISH
  } ctl_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic scan;
    logic shift_init;
    logic shift;
    logic get_rd;
    logic commit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [2:0] func;
    logic       more;
    logic       pend;
    logic       hit;
    logic       get_ok;
    logic       out_free;
  } stat_t;

endpackage

// ===== sv/usmq_ram.sv =====
module usmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/usmq_datapath.sv =====
module usmq_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_func,
  input  logic signed [31:0]  in_value,
  input  logic [5:0]          in_position,
  input  usmq_pkg::cmd_t      cmd,
  output usmq_pkg::stat_t     stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_found,
  output logic signed [31:0]  out_read_value,
  output logic signed [31:0]  out_smallest,
  output logic [6:0]          out_count,
  output logic                out_error
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int IW  = $clog2(CAPACITY + 1);
  localparam int PCW = (IW > 6) ? IW : 6;

  logic [2:0]         func_r;
  logic signed [31:0] value_r;
  logic [5:0]         pos_r;
  logic [IW-1:0]      occ_r, occ_nxt;
  logic signed [31:0] min_r, min_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pidx_r, pidx_nxt;
  logic               hit_r, hit_nxt;
  logic [AW-1:0]      at_r, at_nxt;
  logic signed [31:0] run_min_r, run_min_nxt;
  logic signed [31:0] pmin_r, pmin_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               found_r, found_nxt;
  logic signed [31:0] rdv_r, rdv_nxt;
  logic signed [31:0] small_r, small_nxt;
  logic [6:0]         count_r, count_nxt;
  logic               err_r, err_nxt;

  logic               more, full, get_ok, out_free;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [31:0]        wr_data, rdata;
  logic signed [31:0] rdata_s;

  // result of the operation, valid during commit
  logic [IW-1:0]      occ_c;
  logic signed [31:0] min_c, rdv_c;
  logic               found_c, err_c;

  usmq_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rdata)
  );

  assign rdata_s  = $signed(rdata);
  assign more     = idx_r < occ_r;
  assign full     = occ_r == IW'(CAPACITY);
  assign get_ok   = PCW'(pos_r) < PCW'(occ_r);
  assign out_free = !out_valid_r || out_ready;

  assign stat.func     = func_r;
  assign stat.more     = more;
  assign stat.pend     = pend_r;
  assign stat.hit      = hit_r;
  assign stat.get_ok   = get_ok;
  assign stat.out_free = out_free;

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = occ_r[AW-1:0];
    wr_data = value_r;
    if ((cmd.scan || cmd.shift) && more) begin
      rd_en = 1'b1;
    end
    if (cmd.get_rd) begin
      rd_en   = 1'b1;
      rd_addr = AW'(pos_r);
    end
    if (cmd.shift && pend_r) begin
      // move entry down by one place
      wr_en   = 1'b1;
      wr_addr = pidx_r - AW'(1);
      wr_data = rdata;
    end
    if (cmd.commit && func_r == usmq_pkg::OP_ADD && !full) begin
      wr_en = 1'b1;
    end
  end

  // operation result
  always_comb begin
    occ_c   = occ_r;
    min_c   = min_r;
    rdv_c   = '0;
    found_c = 1'b0;
    err_c   = 1'b0;
    case (func_r)
      usmq_pkg::OP_ADD: begin
        if (full) begin
          err_c = 1'b1;
        end else begin
          occ_c = occ_r + IW'(1);
          if (value_r < min_r) begin
            min_c = value_r;
          end
        end
      end
      usmq_pkg::OP_ERASE: begin
        found_c = hit_r;
        if (hit_r) begin
          occ_c = occ_r - IW'(1);
          min_c = pmin_r;
        end
      end
      usmq_pkg::OP_CONTAINS: begin
        found_c = hit_r;
      end
      usmq_pkg::OP_GET: begin
        if (get_ok) begin
          rdv_c = rdata_s;
        end else begin
          err_c = 1'b1;
        end
      end
      usmq_pkg::OP_CLEAR: begin
        occ_c = '0;
        min_c = usmq_pkg::INT_MAX;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    hit_nxt       = hit_r;
    at_nxt        = at_r;
    run_min_nxt   = run_min_r;
    pmin_nxt      = pmin_r;
    occ_nxt       = occ_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    rdv_nxt       = rdv_r;
    small_nxt     = small_r;
    count_nxt     = count_r;
    err_nxt       = err_r;

    if (cmd.capture) begin
      idx_nxt     = '0;
      pend_nxt    = 1'b0;
      hit_nxt     = 1'b0;
      at_nxt      = '0;
      run_min_nxt = usmq_pkg::INT_MAX;
      pmin_nxt    = usmq_pkg::INT_MAX;
    end

    if (cmd.scan) begin
      pend_nxt = more;
      if (more) begin
        idx_nxt  = idx_r + IW'(1);
        pidx_nxt = idx_r[AW-1:0];
      end
      if (pend_r) begin
        // keep the minimum of the entries ahead of the last match
        if (rdata_s == value_r) begin
          hit_nxt  = 1'b1;
          at_nxt   = pidx_r;
          pmin_nxt = run_min_r;
        end
        if (rdata_s < run_min_r) begin
          run_min_nxt = rdata_s;
        end
      end
    end

    if (cmd.shift_init) begin
      idx_nxt = IW'(at_r) + IW'(1);
    end

    if (cmd.shift) begin
      pend_nxt = more;
      if (more) begin
        idx_nxt  = idx_r + IW'(1);
        pidx_nxt = idx_r[AW-1:0];
      end
      if (pend_r && rdata_s < pmin_r) begin
        pmin_nxt = rdata_s;
      end
    end

    if (cmd.commit) begin
      occ_nxt       = occ_c;
      min_nxt       = min_c;
      out_valid_nxt = 1'b1;
      found_nxt     = found_c;
      rdv_nxt       = rdv_c;
      small_nxt     = min_c;
      count_nxt     = 7'(occ_c);
      err_nxt       = err_c;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      min_r       <= usmq_pkg::INT_MAX;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      min_r       <= min_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    idx_r     <= idx_nxt;
    pidx_r    <= pidx_nxt;
    at_r      <= at_nxt;
    run_min_r <= run_min_nxt;
    pmin_r    <= pmin_nxt;
    found_r   <= found_nxt;
    rdv_r     <= rdv_nxt;
    small_r   <= small_nxt;
    count_r   <= count_nxt;
    err_r     <= err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_read_value = rdv_r;
  assign out_smallest   = small_r;
  assign out_count      = count_r;
  assign out_error      = err_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= IW'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == '0 |-> min_r == usmq_pkg::INT_MAX)
    else $error("empty set with a minimum other than the largest value");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> out_free)
    else $error("result overwritten before it was taken");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && pend_r) |-> (pidx_r != '0) && (IW'(pidx_r) < occ_r))
    else $error("shift write outside the stored entries");

endmodule

// ===== sv/usmq_ctrl.sv =====
module usmq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  usmq_pkg::stat_t stat,
  output usmq_pkg::cmd_t  cmd
);

  usmq_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= usmq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      usmq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = usmq_pkg::ST_DECODE;
        end
      end
      usmq_pkg::ST_DECODE: begin
        if (stat.func inside {usmq_pkg::OP_ERASE, usmq_pkg::OP_CONTAINS}) begin
          state_nxt = usmq_pkg::ST_SCAN;
        end else if (stat.func == usmq_pkg::OP_GET && stat.get_ok) begin
          state_nxt = usmq_pkg::ST_GET_RD;
        end else begin
          state_nxt = usmq_pkg::ST_FINISH;
        end
      end
      usmq_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (!stat.more && !stat.pend) begin
          if (stat.func == usmq_pkg::OP_ERASE && stat.hit) begin
            state_nxt = usmq_pkg::ST_SHIFT_INIT;
          end else begin
            state_nxt = usmq_pkg::ST_FINISH;
          end
        end
      end
      usmq_pkg::ST_SHIFT_INIT: begin
        cmd.shift_init = 1'b1;
        state_nxt      = usmq_pkg::ST_SHIFT;
      end
      usmq_pkg::ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (!stat.more && !stat.pend) begin
          state_nxt = usmq_pkg::ST_FINISH;
        end
      end
      usmq_pkg::ST_GET_RD: begin
        cmd.get_rd = 1'b1;
        state_nxt  = usmq_pkg::ST_FINISH;
      end
      usmq_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = usmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = usmq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/unsorted_set_with_min_query_core.sv =====
// bounded set of signed 32-bit values held in insertion order in a single
// memory of CAPACITY words (one write and one registered read port). each
// item is one request (add, erase, contains, get, clear) and yields exactly
// one result item carrying the match flag, the value read, the minimum of
// the stored values (0x7fffffff when empty) and the entry count after the
// operation. an add to a full set and a get at or beyond the count are
// ignored and flagged on out_error; unused function codes change nothing.
// one item is in work at a time. add, clear and an out-of-range get go from
// decode straight to finish, an in-range get reads one word first, contains
// scans all entries, and erase scans them and then shifts: a scan over
// the entries through the memory read port finds the last match and a second
// pass shifts the later entries down one word a cycle; the minimum is
// carried along both passes, so no extra pass is needed. the longest
// operation is an erase of the first entry of a full set. a finished result
// sits in an output register, and the next item is taken while it waits to
// be collected
module unsorted_set_with_min_query_core #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_value,
  input  logic [5:0]         in_position,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic signed [31:0] out_read_value,
  output logic signed [31:0] out_smallest,
  output logic [6:0]         out_count,
  output logic               out_error
);

  // command and status bundles between sequencer and datapath
  usmq_pkg::cmd_t  cmd;
  usmq_pkg::stat_t stat;

  // sequencer: steps through decode, scan, shift, read and finish
  usmq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: entry memory, count, running minimum and result register
  usmq_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_position   (in_position),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_read_value(out_read_value),
    .out_smallest  (out_smallest),
    .out_count     (out_count),
    .out_error     (out_error)
  );

endmodule
